>>> design/mbpm_pkg.sv
`timescale 1ns / 1ps

package mbpm_pkg;

    localparam int CHANNELS = 16;
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] IN_KIND_CC  = 2'd0;
    localparam logic [1:0] IN_KIND_PGM = 2'd1;

    localparam logic [2:0] OUT_KIND_CC    = 3'd0;
    localparam logic [2:0] OUT_KIND_PGM   = 3'd1;
    localparam logic [2:0] OUT_KIND_OTHER = 3'd2;
    localparam logic [2:0] OUT_KIND_RPN   = 3'd3;
    localparam logic [2:0] OUT_KIND_NRPN  = 3'd4;

    localparam logic [7:0] CC_BANK_HIGH  = 8'd0;
    localparam logic [7:0] CC_BANK_LOW   = 8'd32;
    localparam logic [7:0] CC_RPN_HIGH   = 8'd101;
    localparam logic [7:0] CC_RPN_LOW    = 8'd100;
    localparam logic [7:0] CC_NRPN_HIGH  = 8'd99;
    localparam logic [7:0] CC_NRPN_LOW   = 8'd98;
    localparam logic [7:0] CC_DATA_ENTRY = 8'd6;

    typedef enum logic [3:0] {
        OP_PASS,
        OP_BANK_HIGH,
        OP_BANK_LOW,
        OP_RPN_HIGH,
        OP_RPN_LOW,
        OP_NRPN_HIGH,
        OP_NRPN_LOW,
        OP_DATA,
        OP_PGM
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             ok;
        logic [IDX_W-1:0] idx;
        logic [2:0]       kind;
        logic [4:0]       channel;
        logic [7:0]       key;
        logic [6:0]       value;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  channel;
        logic [21:0] key;
        logic [6:0]  value;
    } res_t;

endpackage

>>> design/mbpm_front.sv
`timescale 1ns / 1ps

module mbpm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          event_kind,
    input  logic [4:0]          channel,
    input  logic [7:0]          key,
    input  logic [6:0]          value,
    output mbpm_pkg::cmd_chan_t cmd_out,
    input  logic                cmd_pop
);
    import mbpm_pkg::*;

    cmd_t       cmd_in;
    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic [4:0] idx_wide;

    always_comb
    begin
        cmd_in.ok      = (channel >= 5'd1) && ({27'd0, channel} <= CHANNELS);
        idx_wide       = channel - 5'd1;
        cmd_in.idx     = cmd_in.ok ? idx_wide[IDX_W-1:0] : '0;
        cmd_in.channel = channel;
        cmd_in.key     = key;
        cmd_in.value   = value;
        cmd_in.op      = OP_PASS;
        cmd_in.kind    = OUT_KIND_OTHER;
        case (event_kind)
            IN_KIND_CC:
            begin
                cmd_in.kind = OUT_KIND_CC;
                case (key)
                    CC_BANK_HIGH:  cmd_in.op = OP_BANK_HIGH;
                    CC_BANK_LOW:   cmd_in.op = OP_BANK_LOW;
                    CC_RPN_HIGH:   cmd_in.op = OP_RPN_HIGH;
                    CC_RPN_LOW:    cmd_in.op = OP_RPN_LOW;
                    CC_NRPN_HIGH:  cmd_in.op = OP_NRPN_HIGH;
                    CC_NRPN_LOW:   cmd_in.op = OP_NRPN_LOW;
                    CC_DATA_ENTRY: cmd_in.op = OP_DATA;
                    default:       cmd_in.op = OP_PASS;
                endcase
            end
            IN_KIND_PGM:
            begin
                cmd_in.kind = OUT_KIND_PGM;
                cmd_in.op   = OP_PGM;
            end
            default:
            begin
                cmd_in.kind = OUT_KIND_OTHER;
                cmd_in.op   = OP_PASS;
            end
        endcase
    end

    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign cmd_out.valid = (count_reg != 2'd0);
    assign cmd_out.cmd   = mem_reg[rd_ptr_reg];

endmodule

>>> design/mbpm_back.sv
`timescale 1ns / 1ps

module mbpm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mbpm_pkg::cmd_chan_t cmd_in,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output logic [2:0]          out_kind,
    output logic [4:0]          out_channel,
    output logic [21:0]         out_key,
    output logic [6:0]          out_value
);
    import mbpm_pkg::*;

    logic [6:0] bank_high_reg   [CHANNELS];
    logic [6:0] bank_low_reg    [CHANNELS];
    logic [6:0] rpn_high_reg    [CHANNELS];
    logic [6:0] rpn_low_reg     [CHANNELS];
    logic [6:0] nrpn_high_reg   [CHANNELS];
    logic [6:0] nrpn_low_reg    [CHANNELS];
    logic       rpn_sel_reg;

    cmd_t       cmd;
    logic       swallow;
    logic       res_full;
    logic       res_push;
    logic       res_pop;
    res_t       res_in;
    logic [6:0] rd_bank_high;
    logic [6:0] rd_bank_low;
    logic [6:0] rd_par_high;
    logic [6:0] rd_par_low;
    logic [6:0] prog;

    res_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign cmd     = cmd_in.cmd;
    assign swallow = (cmd.op != OP_PASS) && (cmd.op != OP_DATA) && (cmd.op != OP_PGM);
    assign cmd_pop = cmd_in.valid && (swallow || !res_full);
    assign res_push = cmd_pop && !swallow;

    always_comb
    begin
        rd_bank_high = cmd.ok ? bank_high_reg[cmd.idx] : 7'd0;
        rd_bank_low  = cmd.ok ? bank_low_reg[cmd.idx] : 7'd0;
        if (rpn_sel_reg)
        begin
            rd_par_high = cmd.ok ? rpn_high_reg[cmd.idx] : 7'd0;
            rd_par_low  = cmd.ok ? rpn_low_reg[cmd.idx] : 7'd0;
        end
        else
        begin
            rd_par_high = cmd.ok ? nrpn_high_reg[cmd.idx] : 7'd0;
            rd_par_low  = cmd.ok ? nrpn_low_reg[cmd.idx] : 7'd0;
        end
        prog           = cmd.key[6:0] - 7'd1;
        res_in.channel = cmd.channel;
        res_in.value   = cmd.value;
        res_in.kind    = cmd.kind;
        res_in.key     = {14'd0, cmd.key};
        case (cmd.op)
            OP_DATA:
            begin
                res_in.kind = rpn_sel_reg ? OUT_KIND_RPN : OUT_KIND_NRPN;
                res_in.key  = {8'd0, rd_par_high, rd_par_low};
            end
            OP_PGM:
            begin
                res_in.key = {1'b0, rd_bank_high, rd_bank_low, prog} + 22'd1;
            end
            default:
            begin
                res_in.kind = cmd.kind;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                bank_high_reg[i] <= 7'd0;
                bank_low_reg[i]  <= 7'd0;
                rpn_high_reg[i]  <= 7'd0;
                rpn_low_reg[i]   <= 7'd0;
                nrpn_high_reg[i] <= 7'd0;
                nrpn_low_reg[i]  <= 7'd0;
            end
            rpn_sel_reg <= 1'b0;
        end
        else if (cmd_pop)
        begin
            case (cmd.op)
                OP_BANK_HIGH:
                begin
                    if (cmd.ok) bank_high_reg[cmd.idx] <= cmd.value;
                end
                OP_BANK_LOW:
                begin
                    if (cmd.ok) bank_low_reg[cmd.idx] <= cmd.value;
                end
                OP_RPN_HIGH:
                begin
                    if (cmd.ok) rpn_high_reg[cmd.idx] <= cmd.value;
                    rpn_sel_reg <= 1'b1;
                end
                OP_RPN_LOW:
                begin
                    if (cmd.ok) rpn_low_reg[cmd.idx] <= cmd.value;
                    rpn_sel_reg <= 1'b1;
                end
                OP_NRPN_HIGH:
                begin
                    if (cmd.ok) nrpn_high_reg[cmd.idx] <= cmd.value;
                    rpn_sel_reg <= 1'b0;
                end
                OP_NRPN_LOW:
                begin
                    if (cmd.ok) nrpn_low_reg[cmd.idx] <= cmd.value;
                    rpn_sel_reg <= 1'b0;
                end
                default:
                begin
                    rpn_sel_reg <= rpn_sel_reg;
                end
            endcase
        end
    end

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign res_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = res_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = res_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, res_push} - {1'b0, res_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            mem_reg[wr_ptr_reg] <= res_in;
        end
    end

    assign out_kind    = mem_reg[rd_ptr_reg].kind;
    assign out_channel = mem_reg[rd_ptr_reg].channel;
    assign out_key     = mem_reg[rd_ptr_reg].key;
    assign out_value   = mem_reg[rd_ptr_reg].value;

endmodule

>>> design/midi_bank_and_parameter_merger.sv
// An event is held in a two-entry front command queue and its result in a two-entry back
// result queue, where it is visible. Throughput: one event per cycle while the result queue
// has room, set by the single execute stage that reads and writes the per-channel stores.
// Controller events that only select a bank or parameter produce no result.
// Reset is asynchronous and active low; it empties both queues and clears all
// per-channel stores and the parameter select flag to zero.
`timescale 1ns / 1ps

module midi_bank_and_parameter_merger (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  event_kind,
    input  logic [4:0]  channel,
    input  logic [7:0]  key,
    input  logic [6:0]  value,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  out_kind,
    output logic [4:0]  out_channel,
    output logic [21:0] out_key,
    output logic [6:0]  out_value
);
    import mbpm_pkg::*;

    cmd_chan_t cmd;
    logic      cmd_pop;

    mbpm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .event_kind (event_kind),
        .channel    (channel),
        .key        (key),
        .value      (value),
        .cmd_out    (cmd),
        .cmd_pop    (cmd_pop)
    );

    mbpm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_in      (cmd),
        .cmd_pop     (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .out_kind    (out_kind),
        .out_channel (out_channel),
        .out_key     (out_key),
        .out_value   (out_value)
    );

    a_pop_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd.valid)
        else $error("command taken from an empty internal queue");

    a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !cmd_pop) |=> empty)
        else $error("result appeared without an executed command");

    a_cmd_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.valid && !(push && !full)) |=> !cmd.valid)
        else $error("command appeared without an input transfer");

endmodule
